@@ hw/rtl/mlrq_pkg.sv @@
// Shared types and codes for the multilevel ready-queue scheduler.
// No dependencies.
`default_nettype none
package mlrq_pkg;
  typedef enum logic [2:0] {
    REQ_ADD = 3'd0, REQ_SCHED = 3'd1, REQ_REMOVE = 3'd2,
    REQ_CHANGE = 3'd3, REQ_END = 3'd4, REQ_TICK = 3'd5
  } req_t;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_BAD_PRI = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [2:0] ADDR_TIME_SLICE = 3'd0;
  typedef struct packed {
    logic [2:0] req;
    logic [5:0] id;
    logic [2:0] pri;
  } cmd_t;
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_POP, S_REQUEUE, S_WALK, S_WALK_RD,
    S_UNLINK, S_PUSH, S_PUSH_WR, S_DONE
  } state_t;
endpackage
`default_nettype wire

@@ hw/rtl/multilevel_ready_queue_scheduler_core.sv @@
// Multilevel ready-queue scheduler: one request in, one result out per request.
// A schedule request scans the levels in up to two passes and requeues the outgoing task; remove,
// change and end of a queued task walk the level's link list.
// Depends on mlrq_pkg, mlrq_front, mlrq_back.
`default_nettype none
module multilevel_ready_queue_scheduler_core
  import mlrq_pkg::*;
#(
  parameter int LEVELS = 5,
  parameter int MAX_TASKS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [5:0]  task_id,
  input  wire logic [2:0]  priority_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [5:0]       next_task,
  output logic [5:0]       prev_task,
  output logic             switched,
  output logic             prev_ended,
  output logic             slice_expired,
  output logic [6:0]       ready_count
);
  logic [15:0] time_slice;
  logic cmd_valid, cmd_take;
  cmd_t cmd;
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TIME_SLICE) ? {16'd0, time_slice} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) time_slice <= 16'd5;
    else if (psel && penable && pwrite && paddr == ADDR_TIME_SLICE)
      time_slice <= pwdata[15:0];
  end
  mlrq_front u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .task_id, .priority_req,
    .cmd_valid, .cmd, .cmd_take
  );
  mlrq_back #(.LEVELS(LEVELS), .MAX_TASKS(MAX_TASKS)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .time_slice, .out_valid, .out_stall,
    .status, .next_task, .prev_task, .switched, .prev_ended, .slice_expired,
    .ready_count
  );
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(next_task))
    else $error("result changed under stall");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ready_count <= 7'(MAX_TASKS))
    else $error("ready count out of range");
  a_switch_prev: assert property (@(posedge clk) disable iff (rst)
    out_valid && !switched |-> prev_task == 6'd0 && !prev_ended)
    else $error("prev fields set without switch");
endmodule
`default_nettype wire

@@ hw/rtl/mlrq_front.sv @@
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on mlrq_pkg.
`default_nettype none
module mlrq_front
  import mlrq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] req_type,
  input  wire logic [5:0] task_id,
  input  wire logic [2:0] priority_req,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_take
);
  cmd_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic push, pop;
  assign in_stall = fill[1];
  assign push = in_valid && !in_stall;
  assign pop = cmd_take && cmd_valid;
  assign cmd_valid = fill != 2'd0;
  assign cmd = slot[rd_ptr];
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{req: req_type, id: task_id, pri: priority_req};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/mlrq_back.sv @@
// Back end: ready queues, link memory, scan and unlink sequencer.
// Depends on mlrq_pkg.
`default_nettype none
module mlrq_back
  import mlrq_pkg::*;
#(
  parameter int LEVELS = 5,
  parameter int MAX_TASKS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_take,
  input  wire logic [15:0] time_slice,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [5:0]       next_task,
  output logic [5:0]       prev_task,
  output logic             switched,
  output logic             prev_ended,
  output logic             slice_expired,
  output logic [6:0]       ready_count
);
  localparam int TW = $clog2(MAX_TASKS);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic [5:0] link_mem [MAX_TASKS];
  logic [5:0] link_rd;
  logic [TW-1:0] link_ra, link_wa;
  logic [5:0] link_wd;
  logic link_we;
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd <= link_mem[link_ra];
  end

  logic [5:0] q_head [LEVELS], q_head_next [LEVELS];
  logic [5:0] q_tail [LEVELS], q_tail_next [LEVELS];
  logic [CW-1:0] q_len [LEVELS], q_len_next [LEVELS];
  logic [CW-1:0] serve [LEVELS], serve_next [LEVELS];
  logic [2:0] lvl [MAX_TASKS];
  logic [TW-1:0] lvl_ra;
  logic [2:0] lvl_rd;
  logic [MAX_TASKS-1:0] lvl_known;
  logic lvl_known_rd;
  logic [MAX_TASKS-1:0] queued, queued_next;
  logic [5:0] running, running_next;
  logic ended_flag, ended_flag_next;
  logic [15:0] slice_left, slice_left_next;
  logic [6:0] total, total_next;
  state_t state, state_next;
  cmd_t cur, cur_next;
  logic [LW-1:0] scan_lv, scan_lv_next;
  logic pass, pass_next;
  logic [5:0] walk, walk_next, old_id, old_id_next;
  logic [CW-1:0] walk_n, walk_n_next;
  logic [2:0] push_lv, push_lv_next;
  logic [5:0] push_id, push_id_next;
  logic lvl_we;
  logic [2:0] lvl_wd;
  logic [1:0] st, st_next;
  logic [5:0] pv, pv_next;
  logic sw, sw_next, pe, pe_next;
  logic after_push_done, after_push_done_next;

  logic id_ok, id_run, id_q;
  logic [2:0] id_lv;
  assign id_ok = {26'd0, cur.id} < MAX_TASKS;
  assign id_run = cur.id == running;
  assign id_q = id_ok && queued[cur.id[TW-1:0]];
  assign id_lv = lvl_known_rd ? lvl_rd : 3'd0;

  always_comb begin
    state_next = state;
    cur_next = cur;
    q_head_next = q_head;
    q_tail_next = q_tail;
    q_len_next = q_len;
    serve_next = serve;
    queued_next = queued;
    running_next = running;
    ended_flag_next = ended_flag;
    slice_left_next = slice_left;
    total_next = total;
    scan_lv_next = scan_lv;
    pass_next = pass;
    walk_next = walk;
    walk_n_next = walk_n;
    old_id_next = old_id;
    push_lv_next = push_lv;
    push_id_next = push_id;
    st_next = st;
    pv_next = pv;
    sw_next = sw;
    pe_next = pe;
    after_push_done_next = after_push_done;
    cmd_take = 1'b0;
    link_we = 1'b0;
    link_wa = '0;
    link_wd = '0;
    link_ra = cur.id[TW-1:0];
    lvl_ra = cur.id[TW-1:0];
    lvl_we = 1'b0;
    lvl_wd = cur.pri;
    unique case (state)
      S_IDLE: begin
        lvl_ra = cmd.id[TW-1:0];
        if (cmd_valid) begin
          cmd_take = 1'b1;
          cur_next = cmd;
          st_next = ST_DONE;
          pv_next = '0;
          sw_next = 1'b0;
          pe_next = 1'b0;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        scan_lv_next = '0;
        pass_next = 1'b0;
        case (cur.req)
          REQ_ADD: begin
            if ({29'd0, cur.pri} >= LEVELS) st_next = ST_BAD_PRI;
            else if (!id_ok) st_next = ST_NONE;
            else if (!id_q && !id_run) begin
              lvl_we = 1'b1;
              push_lv_next = cur.pri;
              push_id_next = cur.id;
              state_next = S_PUSH;
            end
          end
          REQ_SCHED: state_next = S_SCAN;
          REQ_REMOVE: begin
            if (!id_ok || id_run || !id_q) st_next = ST_NONE;
            else state_next = S_WALK;
          end
          REQ_CHANGE: begin
            if ({29'd0, cur.pri} >= LEVELS) st_next = ST_BAD_PRI;
            else if (!id_ok) st_next = ST_NONE;
            else if (!id_run && id_q) state_next = S_WALK;
            else lvl_we = 1'b1;
          end
          REQ_END: begin
            if (!id_ok) st_next = ST_NONE;
            else if (id_run) begin
              ended_flag_next = 1'b1;
              state_next = S_SCAN;
            end else if (id_q) state_next = S_WALK;
          end
          REQ_TICK: if (slice_left != 16'd0) slice_left_next = slice_left - 16'd1;
          default: ;
        endcase
        if (state_next == S_WALK) begin
          walk_next = q_head[id_lv[LW-1:0]];
          walk_n_next = {{(CW-1){1'b0}}, 1'b1};
          link_ra = q_head[id_lv[LW-1:0]][TW-1:0];
        end
      end
      S_SCAN: begin
        if (serve[scan_lv] < q_len[scan_lv]) begin
          state_next = S_POP;
          link_ra = q_head[scan_lv][TW-1:0];
        end else begin
          serve_next[scan_lv] = '0;
          if ({{(32-LW){1'b0}}, scan_lv} == LEVELS - 1) begin
            scan_lv_next = '0;
            pass_next = 1'b1;
            if (pass) begin
              st_next = ST_NONE;
              state_next = S_DONE;
            end
          end else scan_lv_next = scan_lv + 1'b1;
        end
      end
      S_POP: begin
        lvl_ra = running[TW-1:0];
        old_id_next = running;
        running_next = q_head[scan_lv];
        queued_next[q_head[scan_lv][TW-1:0]] = 1'b0;
        if (q_len[scan_lv] > 1) q_head_next[scan_lv] = link_rd;
        q_len_next[scan_lv] = q_len[scan_lv] - 1'b1;
        total_next = total - 7'd1;
        serve_next[scan_lv] = serve[scan_lv] + 1'b1;
        slice_left_next = time_slice;
        pv_next = running;
        sw_next = 1'b1;
        state_next = S_REQUEUE;
      end
      S_REQUEUE: begin
        state_next = S_DONE;
        if (ended_flag) pe_next = 1'b1;
        else if ({29'd0, id_lv} < LEVELS) begin
          push_lv_next = id_lv;
          push_id_next = old_id;
          state_next = S_PUSH;
        end
        ended_flag_next = 1'b0;
      end
      S_WALK: begin
        link_ra = walk[TW-1:0];
        if (q_head[id_lv[LW-1:0]] == cur.id) begin
          if (q_len[id_lv[LW-1:0]] > 1) q_head_next[id_lv[LW-1:0]] = link_rd;
          q_len_next[id_lv[LW-1:0]] = q_len[id_lv[LW-1:0]] - 1'b1;
          total_next = total - 7'd1;
          state_next = S_UNLINK;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (walk_n >= q_len[id_lv[LW-1:0]]) state_next = S_UNLINK;
        else if (link_rd == cur.id) begin
          link_ra = cur.id[TW-1:0];
          state_next = S_WALK_RD;
          walk_n_next = q_len[id_lv[LW-1:0]];
          old_id_next = walk;
          after_push_done_next = 1'b1;
        end else begin
          walk_next = link_rd;
          walk_n_next = walk_n + 1'b1;
          link_ra = link_rd[TW-1:0];
          state_next = S_WALK;
          if ({26'd0, link_rd} >= MAX_TASKS) state_next = S_UNLINK;
        end
        if (after_push_done) begin
          after_push_done_next = 1'b0;
          link_we = 1'b1;
          link_wa = old_id[TW-1:0];
          link_wd = link_rd;
          if (q_tail[id_lv[LW-1:0]] == cur.id) q_tail_next[id_lv[LW-1:0]] = old_id;
          q_len_next[id_lv[LW-1:0]] = q_len[id_lv[LW-1:0]] - 1'b1;
          total_next = total - 7'd1;
          state_next = S_UNLINK;
        end
      end
      S_UNLINK: begin
        queued_next[cur.id[TW-1:0]] = 1'b0;
        state_next = S_DONE;
        if (cur.req == REQ_CHANGE) begin
          lvl_we = 1'b1;
          push_lv_next = cur.pri;
          push_id_next = cur.id;
          state_next = S_PUSH;
        end
      end
      S_PUSH: state_next = S_PUSH_WR;
      S_PUSH_WR: begin
        if (q_len[push_lv[LW-1:0]] == '0) q_head_next[push_lv[LW-1:0]] = push_id;
        else begin
          link_we = 1'b1;
          link_wa = q_tail[push_lv[LW-1:0]][TW-1:0];
          link_wd = push_id;
        end
        q_tail_next[push_lv[LW-1:0]] = push_id;
        q_len_next[push_lv[LW-1:0]] = q_len[push_lv[LW-1:0]] + 1'b1;
        total_next = total + 7'd1;
        queued_next[push_id[TW-1:0]] = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl[cur.id[TW-1:0]] <= lvl_wd;
    lvl_rd <= lvl[lvl_ra];
    lvl_known_rd <= lvl_known[lvl_ra];
    cur <= cur_next;
    walk <= walk_next;
    walk_n <= walk_n_next;
    old_id <= old_id_next;
    push_lv <= push_lv_next;
    push_id <= push_id_next;
    st <= st_next;
    pv <= pv_next;
    sw <= sw_next;
    pe <= pe_next;
    scan_lv <= scan_lv_next;
    pass <= pass_next;
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status <= st;
      next_task <= running;
      prev_task <= pv;
      switched <= sw;
      prev_ended <= pe;
      slice_expired <= slice_left == 16'd0;
      ready_count <= total;
    end
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < LEVELS; i++) begin
        q_head[i] <= '0;
        q_tail[i] <= '0;
        q_len[i] <= '0;
        serve[i] <= '0;
      end
      lvl_known <= '0;
      queued <= '0;
      running <= '0;
      ended_flag <= 1'b0;
      slice_left <= 16'd5;
      total <= '0;
      out_valid <= 1'b0;
      after_push_done <= 1'b0;
    end else begin
      state <= state_next;
      q_head <= q_head_next;
      q_tail <= q_tail_next;
      q_len <= q_len_next;
      serve <= serve_next;
      if (lvl_we) lvl_known[cur.id[TW-1:0]] <= 1'b1;
      queued <= queued_next;
      running <= running_next;
      ended_flag <= ended_flag_next;
      slice_left <= slice_left_next;
      total <= total_next;
      after_push_done <= after_push_done_next;
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire
